// File: rtl/prq_pkg.sv
// Package for the priority bitmap ready queue: operation codes, the back part
// state encoding and the ID width. No dependencies.
`default_nettype none
package prq_pkg;
    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_DEL   = 2'd1,
        OP_SCHED = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_WRITE,
        ST_FIX,
        ST_OUT
    } back_state_t;

    localparam int ID_W = 5;
endpackage
`default_nettype wire

// File: rtl/priority_bitmap_ready_queue.sv
// Top level of the priority bitmap ready queue scheduler.
// Depends on prq_pkg, prq_front and prq_back.
//
// Channel | Dir | Fields (low bit first)
// s_axis  | in  | tdata: mode[1:0], thread_id[6:2], priority_req[11:7]
// m_axis  | out | tdata: next_thread[4:0], switch_needed[5], queue_empty[6],
//         |     |        ready_total[12:7], resched_flag[13]
//
// Each word passes the back part's link memory read and write steps; a delete
// from a set level adds a repair step. A two-entry queue lets the front accept
// words while the back works. Reset clears the bitmap, count, running thread
// and flags; link memories are not cleared. A stalled output holds the back.
`default_nettype none
module priority_bitmap_ready_queue
    import prq_pkg::*;
#(
    parameter int PRIO_LEVELS  = 32,
    parameter int THREAD_SLOTS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // mode, thread_id, priority_req
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata    // next_thread, switch_needed,
                                             // queue_empty, ready_total,
                                             // resched_flag
);
    logic            cmd_valid, cmd_ready;
    op_t             cmd_op;
    logic [ID_W-1:0] cmd_tid, cmd_lvl;

    prq_front #(.PRIO_LEVELS(PRIO_LEVELS), .THREAD_SLOTS(THREAD_SLOTS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_axis_tvalid), .s_tready(s_axis_tready), .s_tdata(s_axis_tdata),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd_op(cmd_op), .cmd_tid(cmd_tid), .cmd_lvl(cmd_lvl)
    );

    prq_back #(.PRIO_LEVELS(PRIO_LEVELS), .THREAD_SLOTS(THREAD_SLOTS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_ready(cmd_ready),
        .cmd_op(cmd_op), .cmd_tid(cmd_tid), .cmd_lvl(cmd_lvl),
        .m_tvalid(m_axis_tvalid), .m_tready(m_axis_tready), .m_tdata(m_axis_tdata)
    );
endmodule
`default_nettype wire

// File: rtl/prq_front.sv
// Front part: accepts input words, validates ranges and queues commands.
// Depends on prq_pkg.
`default_nettype none
module prq_front
    import prq_pkg::*;
#(
    parameter int PRIO_LEVELS  = 32,
    parameter int THREAD_SLOTS = 32
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [15:0]     s_tdata,
    output logic                 cmd_valid,
    input  wire logic            cmd_ready,
    output op_t                  cmd_op,
    output logic [ID_W-1:0]      cmd_tid,
    output logic [ID_W-1:0]      cmd_lvl
);
    localparam int QW = 2 + 2 * ID_W;

    logic [QW-1:0] q_reg [2];
    logic [1:0]    cnt_reg;
    logic          wp_reg;
    logic          rp_reg;
    logic [QW-1:0] word;
    logic          in_ok;
    op_t           op_in;
    logic          push;
    logic          pop;

    always_comb
    begin
        in_ok = ({27'd0, s_tdata[6:2]} < THREAD_SLOTS)
                && ({27'd0, s_tdata[11:7]} < PRIO_LEVELS);
        op_in = op_t'(s_tdata[1:0]);
        if ((op_in == OP_ADD || op_in == OP_DEL) && !in_ok)
        begin
            op_in = OP_NOP;
        end
        word = {s_tdata[11:7], s_tdata[6:2], op_in};
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign push      = s_tvalid && s_tready;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd_op    = op_t'(q_reg[rp_reg][1:0]);
    assign cmd_tid   = q_reg[rp_reg][2+:ID_W];
    assign cmd_lvl   = q_reg[rp_reg][2+ID_W+:ID_W];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule
`default_nettype wire

// File: rtl/prq_back.sv
// Back part: link lists, level bitmap and scheduling with an output register.
// Depends on prq_pkg.
`default_nettype none
module prq_back
    import prq_pkg::*;
#(
    parameter int PRIO_LEVELS  = 32,
    parameter int THREAD_SLOTS = 32
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cmd_valid,
    output logic              cmd_ready,
    input  wire op_t          cmd_op,
    input  wire logic [ID_W-1:0] cmd_tid,
    input  wire logic [ID_W-1:0] cmd_lvl,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [15:0]       m_tdata
);
    localparam int CW = $clog2(THREAD_SLOTS + 1);

    back_state_t st_reg, st_next;
    logic [PRIO_LEVELS-1:0] bm_reg;
    logic [ID_W-1:0] head_mem [PRIO_LEVELS];
    logic [ID_W-1:0] tail_mem [PRIO_LEVELS];
    logic [ID_W-1:0] nxt_mem  [THREAD_SLOTS];
    logic [ID_W-1:0] prv_mem  [THREAD_SLOTS];
    logic [CW-1:0]   cnt_reg;
    logic [ID_W-1:0] run_reg;
    logic            rs_reg;
    op_t             op_reg;
    logic [ID_W-1:0] tid_reg, lvl_reg;
    logic [ID_W-1:0] hd_reg, tl_reg, nx_reg, pv_reg;
    logic            sw_reg;
    logic            sel_found;
    logic [ID_W-1:0] sel_lvl;
    logic            out_full_reg;
    logic [15:0]     out_reg;
    logic            lvl_set;

    always_comb
    begin
        sel_found = 1'b0;
        sel_lvl   = '0;
        for (int i = PRIO_LEVELS - 1; i >= 0; i--)
        begin
            if (bm_reg[i])
            begin
                sel_found = 1'b1;
                sel_lvl   = ID_W'(i);
            end
        end
    end

    assign lvl_set   = bm_reg[lvl_reg];
    assign cmd_ready = (st_reg == ST_IDLE);
    assign m_tvalid  = out_full_reg;
    assign m_tdata   = out_reg;

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:  if (cmd_valid) st_next = ST_READ;
            ST_READ:  st_next = ST_WRITE;
            ST_WRITE: st_next = (op_reg == OP_DEL && lvl_set) ? ST_FIX : ST_OUT;
            ST_FIX:   st_next = ST_OUT;
            ST_OUT:   if (!out_full_reg || m_tready) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                op_reg  <= cmd_op;
                tid_reg <= cmd_tid;
                lvl_reg <= cmd_lvl;
            end
            ST_READ:
            begin
                hd_reg <= head_mem[lvl_reg];
                tl_reg <= tail_mem[lvl_reg];
                nx_reg <= nxt_mem[tid_reg];
                pv_reg <= prv_mem[tid_reg];
                if (op_reg == OP_SCHED)
                begin
                    hd_reg <= head_mem[sel_lvl];
                end
            end
            ST_WRITE:
            begin
                if (op_reg == OP_ADD)
                begin
                    tail_mem[lvl_reg] <= tid_reg;
                    if (lvl_set)
                    begin
                        nxt_mem[tl_reg] <= tid_reg;
                        prv_mem[tid_reg] <= tl_reg;
                    end
                    else
                    begin
                        head_mem[lvl_reg] <= tid_reg;
                    end
                end
                else if (op_reg == OP_DEL && lvl_set)
                begin
                    if (hd_reg == tid_reg && tl_reg != tid_reg)
                    begin
                        head_mem[lvl_reg] <= nx_reg;
                    end
                    else if (hd_reg != tid_reg)
                    begin
                        nxt_mem[pv_reg] <= nx_reg;
                    end
                end
            end
            ST_FIX:
            begin
                if (!(hd_reg == tid_reg && tl_reg == tid_reg))
                begin
                    if (tl_reg == tid_reg)
                    begin
                        tail_mem[lvl_reg] <= pv_reg;
                    end
                    else
                    begin
                        prv_mem[nx_reg] <= pv_reg;
                    end
                end
            end
            default:
            begin
            end
        endcase
        if (st_reg == ST_OUT && (!out_full_reg || m_tready))
        begin
            out_reg <= {2'b00, rs_reg, 6'(cnt_reg), ~(|bm_reg), sw_reg, run_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg       <= ST_IDLE;
            bm_reg       <= '0;
            cnt_reg      <= '0;
            run_reg      <= '0;
            rs_reg       <= 1'b0;
            sw_reg       <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_full_reg && m_tready)
            begin
                out_full_reg <= 1'b0;
            end
            if (st_reg == ST_OUT && (!out_full_reg || m_tready))
            begin
                out_full_reg <= 1'b1;
            end
            if (st_reg == ST_READ)
            begin
                sw_reg <= 1'b0;
            end
            if (st_reg == ST_WRITE)
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        bm_reg[lvl_reg] <= 1'b1;
                        if (cnt_reg != CW'(THREAD_SLOTS))
                        begin
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        rs_reg <= 1'b1;
                    end
                    OP_DEL:
                    begin
                        if (lvl_set)
                        begin
                            if (hd_reg == tid_reg && tl_reg == tid_reg)
                            begin
                                bm_reg[lvl_reg] <= 1'b0;
                            end
                            if (cnt_reg != '0)
                            begin
                                cnt_reg <= cnt_reg - 1'b1;
                            end
                            rs_reg <= 1'b1;
                        end
                    end
                    OP_SCHED:
                    begin
                        rs_reg <= 1'b0;
                        if (sel_found && hd_reg != run_reg)
                        begin
                            run_reg <= hd_reg;
                            sw_reg  <= 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/prq_checker.sv
// Port-level checker for the ready queue, bound to the top level.
// Depends on priority_bitmap_ready_queue ports only.
`default_nettype none
module prq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output word changed under stall");
    a_switch: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5] |-> !m_axis_tdata[6])
        else $error("switch flagged with all levels empty");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[12:7] <= 6'd32)
        else $error("count out of range");
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !m_axis_tdata[15] && !m_axis_tdata[14])
        else $error("padding bits set");
endmodule

bind priority_bitmap_ready_queue prq_checker u_prq_checker (
    .clk(clk), .rst_n(rst_n),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire

// File: dv/priority_bitmap_ready_queue_tb.sv
// Self-checking testbench for priority_bitmap_ready_queue: a directed pass, then random
// add/delete/schedule traffic under several idle and stall patterns, checked against a model.
// Depends on prq_pkg and the RTL of the block; nothing else.
`default_nettype none
module priority_bitmap_ready_queue_tb;
    import prq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LEVELS = 32;
    localparam int SLOTS = 32;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic       resched_flag;
        logic [5:0] ready_total;
        logic       queue_empty;
        logic       switch_needed;
        logic [4:0] next_thread;
    } status_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;   // mode[1:0], thread_id[6:2], priority_req[11:7]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // next_thread[4:0], switch_needed[5], queue_empty[6],
                                 // ready_total[12:7], resched_flag[13]

    logic [31:0] lvl_bitmap;
    logic [4:0]  lvl_head [LEVELS];
    logic [4:0]  lvl_tail [LEVELS];
    logic [4:0]  succ [SLOTS];
    logic [4:0]  pred [SLOTS];
    bit          succ_set [SLOTS];
    bit          pred_set [SLOTS];
    logic [5:0]  ready_cnt;
    logic [4:0]  running;
    logic        resched;

    status_t     status_q [$];
    logic [9:0]  queued [$];
    int          errors;
    int          cycles;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    priority_bitmap_ready_queue u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("priority_bitmap_ready_queue regression: fail");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        status_t got;
        status_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = status_t'(m_axis_tdata[13:0]);
            if (status_q.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, got);
                errors++;
            end
            else
            begin
                want = status_q.pop_front();
                if (got.next_thread !== want.next_thread)
                begin
                    $display("%0t: next_thread exp %0d got %0d", $time,
                             want.next_thread, got.next_thread);
                    errors++;
                end
                if (got.switch_needed !== want.switch_needed)
                begin
                    $display("%0t: switch_needed exp %0d got %0d", $time,
                             want.switch_needed, got.switch_needed);
                    errors++;
                end
                if (got.queue_empty !== want.queue_empty)
                begin
                    $display("%0t: queue_empty exp %0d got %0d", $time,
                             want.queue_empty, got.queue_empty);
                    errors++;
                end
                if (got.ready_total !== want.ready_total)
                begin
                    $display("%0t: ready_total exp %0d got %0d", $time,
                             want.ready_total, got.ready_total);
                    errors++;
                end
                if (got.resched_flag !== want.resched_flag)
                begin
                    $display("%0t: resched_flag exp %0d got %0d", $time,
                             want.resched_flag, got.resched_flag);
                    errors++;
                end
            end
        end
    end

    task automatic update_ready_queue(input op_t op, input logic [4:0] tid,
                                      input logic [4:0] lvl);
        status_t st;
        bit      at_head;
        bit      at_tail;
        st = '0;
        case (op)
            OP_ADD:
            begin
                if (lvl_bitmap[lvl])
                begin
                    succ[lvl_tail[lvl]] = tid;
                    succ_set[lvl_tail[lvl]] = 1'b1;
                    pred[tid] = lvl_tail[lvl];
                    pred_set[tid] = 1'b1;
                    lvl_tail[lvl] = tid;
                end
                else
                begin
                    lvl_head[lvl] = tid;
                    lvl_tail[lvl] = tid;
                    lvl_bitmap[lvl] = 1'b1;
                end
                if (ready_cnt < SLOTS)
                    ready_cnt++;
                resched = 1'b1;
            end
            OP_DEL:
            begin
                if (lvl_bitmap[lvl])
                begin
                    at_head = (lvl_head[lvl] == tid);
                    at_tail = (lvl_tail[lvl] == tid);
                    if (at_head && at_tail)
                        lvl_bitmap[lvl] = 1'b0;
                    else
                    begin
                        if (at_head)
                            lvl_head[lvl] = succ[tid];
                        else
                        begin
                            succ[pred[tid]] = succ[tid];
                            succ_set[pred[tid]] = 1'b1;
                        end
                        if (at_tail)
                            lvl_tail[lvl] = pred[tid];
                        else
                        begin
                            pred[succ[tid]] = pred[tid];
                            pred_set[succ[tid]] = 1'b1;
                        end
                    end
                    if (ready_cnt > 0)
                        ready_cnt--;
                    resched = 1'b1;
                end
            end
            OP_SCHED:
            begin
                resched = 1'b0;
                for (int l = 0; l < LEVELS; l++)
                begin
                    if (lvl_bitmap[l])
                    begin
                        if (lvl_head[l] != running)
                        begin
                            running = lvl_head[l];
                            st.switch_needed = 1'b1;
                        end
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        st.next_thread = running;
        st.queue_empty = (lvl_bitmap == '0);
        st.ready_total = ready_cnt;
        st.resched_flag = resched;
        status_q.push_back(st);
    endtask

    // A delete that unlinks from the middle reads both link entries of the thread,
    // which must have been written before.
    function automatic bit delete_is_safe(input logic [4:0] tid, input logic [4:0] lvl);
        return !lvl_bitmap[lvl] || (lvl_head[lvl] == tid && lvl_tail[lvl] == tid)
               || (succ_set[tid] && pred_set[tid]);
    endfunction

    task automatic send_word(input op_t op, input logic [4:0] tid, input logic [4:0] lvl);
        op_t use_op;
        use_op = op;
        if (op == OP_DEL && !delete_is_safe(tid, lvl))
            use_op = OP_SCHED;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, lvl, tid, use_op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        update_ready_queue(use_op, tid, lvl);
    endtask

    task automatic stop_sending();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drain();
        stop_sending();
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_word(OP_SCHED, 5'd0, 5'd0);
        send_word(OP_NOP, 5'd31, 5'd31);
        send_word(OP_DEL, 5'd4, 5'd9);
        send_word(OP_ADD, 5'd31, 5'd31);
        send_word(OP_SCHED, 5'd0, 5'd0);
        send_word(OP_ADD, 5'd0, 5'd0);
        send_word(OP_ADD, 5'd5, 5'd0);
        send_word(OP_SCHED, 5'd0, 5'd0);
        send_word(OP_ADD, 5'd1, 5'd3);
        send_word(OP_ADD, 5'd2, 5'd3);
        send_word(OP_ADD, 5'd3, 5'd3);
        send_word(OP_DEL, 5'd2, 5'd3);
        send_word(OP_DEL, 5'd3, 5'd3);
        send_word(OP_DEL, 5'd0, 5'd0);
        send_word(OP_SCHED, 5'd0, 5'd0);
        send_word(OP_ADD, 5'd5, 5'd0);
        send_word(OP_DEL, 5'd5, 5'd0);
        send_word(OP_DEL, 5'd5, 5'd0);
        send_word(OP_DEL, 5'd1, 5'd3);
        send_word(OP_DEL, 5'd31, 5'd31);
        send_word(OP_SCHED, 5'd0, 5'd0);
        send_word(OP_SCHED, 5'd0, 5'd0);
        wait_drain();
    endtask

    task automatic random_item();
        int         pick;
        int         idx;
        logic [4:0] tid;
        logic [4:0] lvl;
        pick = $urandom_range(99);
        if (queued.size() > 40)
            pick = 50;
        if (pick < 45 || (pick < 80 && queued.size() == 0))
        begin
            tid = 5'($urandom);
            lvl = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(3));
            queued.push_back({lvl, tid});
            send_word(OP_ADD, tid, lvl);
        end
        else if (pick < 80)
        begin
            idx = $urandom_range(queued.size() - 1);
            {lvl, tid} = queued[idx];
            queued.delete(idx);
            send_word(OP_DEL, tid, lvl);
        end
        else if (pick < 94)
            send_word(OP_SCHED, 5'($urandom), 5'($urandom));
        else if (pick < 97)
            send_word(OP_NOP, 5'($urandom), 5'($urandom));
        else
            send_word(OP_DEL, 5'($urandom), 5'($urandom));
    endtask

    task automatic test_random(input int count, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            random_item();
        wait_drain();
    endtask

    task automatic test_output_hold_off();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 200;
        for (int i = 0; i < 30; i++)
            random_item();
        wait_drain();
    endtask

    initial
    begin
        errors = 0;
        cycles = 0;
        hold_cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        lvl_bitmap = '0;
        ready_cnt = '0;
        running = '0;
        resched = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            succ_set[i] = 1'b0;
            pred_set[i] = 1'b0;
        end
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random(400, 0, 0);
        test_random(400, 55, 0);
        test_random(400, 0, 55);
        test_output_hold_off();
        test_random(400, 11, 11);
        if (errors == 0)
            $display("priority_bitmap_ready_queue regression: pass");
        else
            $display("priority_bitmap_ready_queue regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
